@@ rtl/tdhp_pkg.sv @@
`timescale 1ns / 1ps

package tdhp_pkg;

    localparam int MAX_DATAGRAM = 2048;
    localparam int CNT_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int DECL_CAP     = MAX_DATAGRAM + 1;
    localparam int DECL_W       = $clog2(MAX_DATAGRAM + 2);
    localparam int PROD_W       = DECL_W + 4;
    localparam int APB_ADDR_W   = 3;

    localparam logic [5:0] META_MAX_DIGITS = 6'd31;
    localparam logic [5:0] DIGIT_CNT_MAX   = 6'd63;
    localparam int         SEQ_MAX_DIGITS  = 20;
    localparam int         PAY_OUT_MAX     = 4095;

    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_PIPE     = 8'h7C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [7:0] CFG_LEN_RESET = 8'd32;
    localparam logic       REG_SRC_MAX   = 1'b0;
    localparam logic       REG_CHAN_MAX  = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_LEN,
        PH_SRC,
        PH_SEQ,
        PH_CHAN,
        PH_PAY,
        PH_DEAD
    } t_phase;

    typedef enum logic [2:0] {
        RG_ENV,
        RG_SOURCE,
        RG_SEQ,
        RG_CHAN,
        RG_PAYLOAD,
        RG_DROP
    } t_region;

    typedef enum logic [3:0] {
        ST_OK,
        ST_MAGIC,
        ST_NO_BRACKET,
        ST_META_LEN,
        ST_LEN_DIGITS,
        ST_MISMATCH,
        ST_NO_PIPE,
        ST_COLON1,
        ST_COLON2,
        ST_BOUNDS,
        ST_SEQ_DIGITS
    } t_status;

    typedef struct packed {
        logic [7:0] src_max;
        logic [7:0] chan_max;
    } t_cfg;

    function automatic logic [9:0] err_mask(input t_status s);
        err_mask = 10'b1 << (4'(s) - 4'd1);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic in_body(input t_phase p);
        in_body = (p == PH_SRC) || (p == PH_SEQ) || (p == PH_CHAN) || (p == PH_PAY);
    endfunction

    // expected prefix byte at positions zero to five
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        unique case (idx)
            3'd0:    magic_byte = 8'h42;
            3'd1:    magic_byte = 8'h43;
            3'd2:    magic_byte = 8'h43;
            3'd3:    magic_byte = 8'h4E;
            3'd4:    magic_byte = 8'h31;
            3'd5:    magic_byte = 8'h5B;
            default: magic_byte = 8'h00;
        endcase
    endfunction

endpackage

@@ rtl/tdhp_if.sv @@
`timescale 1ns / 1ps

interface tdhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tdhp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  echo_byte;
    logic [2:0]  region;
    logic        datagram_end;
    logic [3:0]  status;
    logic [63:0] sequence_value;
    logic [7:0]  source_length;
    logic [7:0]  channel_length;
    logic [11:0] payload_length;

    modport source (
        output valid, output echo_byte, output region, output datagram_end,
        output status, output sequence_value, output source_length,
        output channel_length, output payload_length, input ready
    );
    modport sink (
        input valid, input echo_byte, input region, input datagram_end,
        input status, input sequence_value, input source_length,
        input channel_length, input payload_length, output ready
    );
endinterface

@@ rtl/tdhp_apb_regs.sv @@
`timescale 1ns / 1ps

module tdhp_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdhp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output tdhp_pkg::t_cfg                      o_cfg
);
    import tdhp_pkg::*;

    logic [7:0] r_src_max;
    logic [7:0] r_chan_max;
    logic       n_wr;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_max  <= CFG_LEN_RESET;
            r_chan_max <= CFG_LEN_RESET;
        end else if (n_wr) begin
            if (paddr[2] == REG_SRC_MAX) begin
                r_src_max <= pwdata[7:0];
            end
            if (paddr[2] == REG_CHAN_MAX) begin
                r_chan_max <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SRC_MAX) begin
            prdata[7:0] = r_src_max;
        end else begin
            prdata[7:0] = r_chan_max;
        end
    end

    assign o_cfg.src_max  = r_src_max;
    assign o_cfg.chan_max = r_chan_max;

endmodule

@@ rtl/tdhp_in_stage.sv @@
`timescale 1ns / 1ps

module tdhp_in_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    tdhp_in_if.sink   i_in,
    tdhp_in_if.source o_mid
);
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_fin;

    assign i_in.ready = !r_valid || o_mid.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data <= i_in.data_byte;
            r_fin  <= i_in.final_byte;
        end
    end

    assign o_mid.valid      = r_valid;
    assign o_mid.data_byte  = r_data;
    assign o_mid.final_byte = r_fin;

endmodule

@@ rtl/tdhp_parse.sv @@
`timescale 1ns / 1ps

module tdhp_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tdhp_pkg::t_cfg i_cfg,
    tdhp_in_if.sink        i_mid,
    tdhp_out_if.source     o_out
);
    import tdhp_pkg::*;

    // datagram state
    logic [CNT_W-1:0]  r_pos,      n_pos;
    t_phase            r_phase,    n_phase;
    logic [DECL_W-1:0] r_decl,     n_decl;
    logic [5:0]        r_ndig,     n_ndig;
    logic [CNT_W-1:0]  r_body,     n_body;
    logic [CNT_W-1:0]  r_src_cnt,  n_src_cnt;
    logic [CNT_W-1:0]  r_seq_cnt,  n_seq_cnt;
    logic [CNT_W-1:0]  r_chan_cnt, n_chan_cnt;
    logic [CNT_W-1:0]  r_pay_cnt,  n_pay_cnt;
    logic [63:0]       r_seq,      n_seq;
    logic [9:0]        r_err,      n_err;

    // result register
    logic        r_valid;
    logic [7:0]  r_echo,   n_echo;
    logic [2:0]  r_region, n_region;
    logic        r_end,    n_end;
    logic [3:0]  r_status, n_status;
    logic [63:0] r_seqv,   n_seqv;
    logic [7:0]  r_srcl,   n_srcl;
    logic [7:0]  r_chnl,   n_chnl;
    logic [11:0] r_payl,   n_payl;

    logic              fire;
    logic [7:0]        b;
    logic [3:0]        digit;
    logic [PROD_W-1:0] v_prod;
    logic [67:0]       v_seq_prod;
    logic [9:0]        v_err;
    t_status           v_status;
    t_region           v_region;

    assign i_mid.ready = !r_valid || o_out.ready;
    assign fire        = i_mid.valid && i_mid.ready;
    assign b           = i_mid.data_byte;
    assign digit       = 4'(b - CH_ZERO);
    assign v_prod      = ({4'b0, r_decl} << 3) + ({4'b0, r_decl} << 1) + PROD_W'(digit);
    assign v_seq_prod  = ({4'b0, r_seq} << 3) + ({4'b0, r_seq} << 1) + 68'(digit);

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_decl     = r_decl;
        n_ndig     = r_ndig;
        n_body     = r_body;
        n_src_cnt  = r_src_cnt;
        n_seq_cnt  = r_seq_cnt;
        n_chan_cnt = r_chan_cnt;
        n_pay_cnt  = r_pay_cnt;
        n_seq      = r_seq;
        n_err      = r_err;
        v_region   = RG_ENV;
        v_err      = '0;
        v_status   = ST_OK;

        if (r_pos >= CNT_W'(MAX_DATAGRAM)) begin
            v_region = RG_DROP;
        end else begin
            n_pos = r_pos + 1'b1;
            if (in_body(r_phase)) begin
                n_body = r_body + 1'b1;
            end
            unique case (r_phase)
                PH_MAGIC: begin
                    if (b != magic_byte(r_pos[2:0])) begin
                        n_err = n_err | err_mask(ST_MAGIC);
                    end
                    if (r_pos == CNT_W'(5)) begin
                        n_phase = ((n_err & err_mask(ST_MAGIC)) != '0) ? PH_DEAD : PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b == CH_RBRACKET) begin
                        if (r_ndig == '0 || r_ndig > META_MAX_DIGITS) begin
                            n_err = n_err | err_mask(ST_META_LEN);
                        end
                        n_phase = PH_SRC;
                    end else begin
                        if (r_ndig < DIGIT_CNT_MAX) begin
                            n_ndig = r_ndig + 1'b1;
                        end
                        if (is_digit(b)) begin
                            n_decl = (v_prod > PROD_W'(DECL_CAP)) ? DECL_W'(DECL_CAP)
                                                                  : DECL_W'(v_prod);
                        end else begin
                            n_err = n_err | err_mask(ST_LEN_DIGITS);
                        end
                    end
                end
                PH_SRC: begin
                    if (b == CH_COLON) begin
                        n_phase = PH_SEQ;
                    end else if (b == CH_PIPE) begin
                        n_err   = n_err | err_mask(ST_COLON1);
                        n_phase = PH_PAY;
                    end else begin
                        v_region  = RG_SOURCE;
                        n_src_cnt = r_src_cnt + 1'b1;
                    end
                end
                PH_SEQ: begin
                    if (b == CH_COLON) begin
                        n_phase = PH_CHAN;
                    end else if (b == CH_PIPE) begin
                        n_err   = n_err | err_mask(ST_COLON2);
                        n_phase = PH_PAY;
                    end else begin
                        v_region  = RG_SEQ;
                        n_seq_cnt = r_seq_cnt + 1'b1;
                        if (is_digit(b)) begin
                            n_seq = (v_seq_prod[67:64] != 4'd0) ? '1 : v_seq_prod[63:0];
                        end else begin
                            n_err = n_err | err_mask(ST_SEQ_DIGITS);
                        end
                    end
                end
                PH_CHAN: begin
                    if (b == CH_PIPE) begin
                        n_phase = PH_PAY;
                    end else begin
                        v_region   = RG_CHAN;
                        n_chan_cnt = r_chan_cnt + 1'b1;
                    end
                end
                PH_PAY: begin
                    v_region  = RG_PAYLOAD;
                    n_pay_cnt = r_pay_cnt + 1'b1;
                end
                PH_DEAD: begin
                end
                default: begin
                end
            endcase
        end

        n_echo   = b;
        n_region = v_region;
        n_end    = i_mid.final_byte;
        n_status = ST_OK;
        n_seqv   = '0;
        n_srcl   = '0;
        n_chnl   = '0;
        n_payl   = '0;

        if (i_mid.final_byte) begin
            v_err = n_err;
            if (n_pos < CNT_W'(8)) begin
                v_err = v_err | err_mask(ST_MAGIC);
            end
            if (n_phase == PH_LEN) begin
                v_err = v_err | err_mask(ST_NO_BRACKET);
            end
            if (in_body(n_phase) && DECL_W'(n_body) != n_decl) begin
                v_err = v_err | err_mask(ST_MISMATCH);
            end
            if (in_body(n_phase) && n_phase != PH_PAY) begin
                v_err = v_err | err_mask(ST_NO_PIPE);
            end
            if (n_phase == PH_PAY
                && (32'(n_src_cnt) > 32'(i_cfg.src_max)
                    || 32'(n_chan_cnt) > 32'(i_cfg.chan_max)
                    || n_seq_cnt == '0
                    || 32'(n_seq_cnt) > 32'(SEQ_MAX_DIGITS))) begin
                v_err = v_err | err_mask(ST_BOUNDS);
            end
            // lowest set flag wins
            for (int i = 9; i >= 0; i--) begin
                if (v_err[i]) begin
                    v_status = t_status'(4'(i + 1));
                end
            end
            n_status = v_status;
            if (v_status == ST_OK) begin
                n_seqv = n_seq;
                n_srcl = 8'(n_src_cnt);
                n_chnl = 8'(n_chan_cnt);
                n_payl = (32'(n_pay_cnt) > 32'(PAY_OUT_MAX)) ? 12'(PAY_OUT_MAX)
                                                             : 12'(n_pay_cnt);
            end
            n_pos      = '0;
            n_phase    = PH_MAGIC;
            n_decl     = '0;
            n_ndig     = '0;
            n_body     = '0;
            n_src_cnt  = '0;
            n_seq_cnt  = '0;
            n_chan_cnt = '0;
            n_pay_cnt  = '0;
            n_seq      = '0;
            n_err      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_MAGIC;
            r_decl     <= '0;
            r_ndig     <= '0;
            r_body     <= '0;
            r_src_cnt  <= '0;
            r_seq_cnt  <= '0;
            r_chan_cnt <= '0;
            r_pay_cnt  <= '0;
            r_seq      <= '0;
            r_err      <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_pos      <= n_pos;
                r_phase    <= n_phase;
                r_decl     <= n_decl;
                r_ndig     <= n_ndig;
                r_body     <= n_body;
                r_src_cnt  <= n_src_cnt;
                r_seq_cnt  <= n_seq_cnt;
                r_chan_cnt <= n_chan_cnt;
                r_pay_cnt  <= n_pay_cnt;
                r_seq      <= n_seq;
                r_err      <= n_err;
            end
            if (i_mid.ready) begin
                r_valid <= i_mid.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_echo   <= n_echo;
            r_region <= n_region;
            r_end    <= n_end;
            r_status <= n_status;
            r_seqv   <= n_seqv;
            r_srcl   <= n_srcl;
            r_chnl   <= n_chnl;
            r_payl   <= n_payl;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.echo_byte      = r_echo;
    assign o_out.region         = r_region;
    assign o_out.datagram_end   = r_end;
    assign o_out.status         = r_status;
    assign o_out.sequence_value = r_seqv;
    assign o_out.source_length  = r_srcl;
    assign o_out.channel_length = r_chnl;
    assign o_out.payload_length = r_payl;

endmodule

@@ rtl/text_datagram_header_parser.sv @@
`timescale 1ns / 1ps

// streaming header checker for text datagrams: one byte beat per clock in while the
// output side does not stall, one tagged byte beat out, with the verdict (status,
// sequence, field lengths) on the beat that carries the end flag. the block sustains
// one byte per cycle under that condition; a byte goes through an input register and
// a result register. i_in.ready follows o_out.ready through the two register stages.
// there is no clearing pass after reset; the user must write the length limits
// through the apb port while no datagram is in flight; the block does not enforce it.
module text_datagram_header_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdhp_in_if.sink                         i_in,
    tdhp_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdhp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tdhp_pkg::*;

    t_cfg cfg;

    tdhp_in_if mid ();

    tdhp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tdhp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_mid   (mid.source)
    );

    tdhp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_mid   (mid.sink),
        .o_out   (o_out)
    );

    // verdict fields stay zero off the end beat
    a_no_verdict_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.datagram_end) |->
            (o_out.status == ST_OK && o_out.sequence_value == '0
             && o_out.source_length == '0 && o_out.channel_length == '0
             && o_out.payload_length == '0))
        else $error("verdict fields set on a beat without end flag");

    // a failed datagram reports no lengths or sequence
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
            (o_out.sequence_value == '0 && o_out.source_length == '0
             && o_out.channel_length == '0 && o_out.payload_length == '0))
        else $error("lengths reported with a failing status");

    // an ok verdict keeps the configured bounds
    a_ok_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.datagram_end && o_out.status == ST_OK
         && $stable(cfg)) |->
            (o_out.source_length <= cfg.src_max
             && o_out.channel_length <= cfg.chan_max))
        else $error("ok verdict beyond configured length");

endmodule
